// File: rtl/core/piecewise_linear_table_interp_core_defines.svh
// Assertion macros shared by the interpolation core.
`ifndef PIECEWISE_LINEAR_TABLE_INTERP_CORE_DEFINES_SVH
`define PIECEWISE_LINEAR_TABLE_INTERP_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, masked during reset
`define PLTI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, masked during reset
`define PLTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PLTI_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PLTI_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/plti_pkg.sv
package plti_pkg;

    // Table geometry
    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Field widths
    localparam int DATA_W  = 16;
    localparam int PTS_W   = 5;
    localparam int OUT_W   = 3;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Saturation limits of a Q4.11 value
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Register indexes (word address bit)
    localparam logic REG_POINTS = 1'b0;

    // Result outcome codes
    typedef enum logic [OUT_W-1:0] {
        OUT_WRITE,
        OUT_EMPTY,
        OUT_SINGLE,
        OUT_BELOW,
        OUT_ABOVE,
        OUT_FLAT,
        OUT_INTERP
    } t_outcome;

    // One breakpoint
    typedef struct packed {
        logic signed [DATA_W-1:0] angle;
        logic signed [DATA_W-1:0] value;
    } t_entry;

endpackage

// File: rtl/core/plti_mul.sv
// Bit-serial shift-add multiplier for unsigned magnitudes.
// One multiplier bit per cycle; o_done pulses when o_prod is final.
module plti_mul (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [plti_pkg::DATA_W-1:0]     i_mcand,
    input  logic [plti_pkg::DATA_W-1:0]     i_mplier,
    output logic                            o_done,
    output logic [2*plti_pkg::DATA_W-1:0]   o_prod
);

    localparam int W      = plti_pkg::DATA_W;
    localparam int STEP_W = $clog2(W);

    logic [W-1:0]      r_hi;
    logic [W-1:0]      r_lo;
    logic [W-1:0]      r_mcand;
    logic [STEP_W-1:0] r_step;
    logic              r_run;
    logic              r_done;
    logic [W:0]        sum;

    // Add the multiplicand when the current multiplier bit is set
    always_comb begin
        sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : {(W+1){1'b0}});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: accumulator and multiplier share one right-shifting register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hi    <= '0;
            r_lo    <= i_mplier;
            r_mcand <= i_mcand;
        end else if (r_run) begin
            r_hi <= sum[W:1];
            r_lo <= {sum[0], r_lo[W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

// File: rtl/core/plti_div.sv
// Bit-serial restoring divider. The upper half of the dividend must be
// below the divisor, so the quotient fits in DATA_W bits.
module plti_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [2*plti_pkg::DATA_W-1:0]   i_dividend,
    input  logic [plti_pkg::DATA_W-1:0]     i_divisor,
    output logic                            o_done,
    output logic [plti_pkg::DATA_W-1:0]     o_quo
);

    localparam int W      = plti_pkg::DATA_W;
    localparam int STEP_W = $clog2(W);

    logic [W-1:0]      r_rem;
    logic [W-1:0]      r_quo;
    logic [W-1:0]      r_div;
    logic [STEP_W-1:0] r_step;
    logic              r_run;
    logic              r_done;
    logic [W:0]        trial;

    // Trial subtract of the divisor from the shifted remainder
    always_comb begin
        trial = {r_rem, r_quo[W-1]} - {1'b0, r_div};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend low half shifts out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[2*W-1:W];
            r_quo <= i_dividend[W-1:0];
            r_div <= i_divisor;
        end else if (r_run) begin
            if (!trial[W]) begin
                r_rem <= trial[W-1:0];
            end else begin
                r_rem <= {r_rem[W-2:0], r_quo[W-1]};
            end
            r_quo <= {r_quo[W-2:0], ~trial[W]};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: rtl/core/piecewise_linear_table_interp_core.sv
// Piecewise-linear curve lookup over a 16-entry breakpoint table. A write
// transaction (operation 0) stores one angle/value pair and reports outcome 0
// in the cycle after start. A sample transaction reads the table through a
// single registered-read port: end checks on the first and last entries, a
// binary search (at most 5 probes at 16 points), a fetch of the bracketing
// entries, then a bit-serial multiply followed by a bit-serial divide; a
// product too large for the divider skips the divide and saturates. busy is
// high while a sample walks the table; start is taken only while busy is low.
// Each result appears for exactly one cycle with o_valid high and cannot be
// held off, so the receiver must capture it in that cycle. The user must write
// points_in_use over the APB port only while the core is idle; the core does
// not enforce this. pready is always high.
`include "piecewise_linear_table_interp_core_defines.svh"

module piecewise_linear_table_interp_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Command channel
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_operation,
    input  logic [plti_pkg::IDX_W-1:0]          i_entry_index,
    input  logic signed [plti_pkg::DATA_W-1:0]  i_entry_angle,
    input  logic signed [plti_pkg::DATA_W-1:0]  i_entry_value,
    input  logic signed [plti_pkg::DATA_W-1:0]  i_angle,
    // Result channel
    output logic                                o_valid,
    output logic signed [plti_pkg::DATA_W-1:0]  o_value,
    output logic [plti_pkg::OUT_W-1:0]          o_outcome,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [plti_pkg::PADDR_W-1:0]        paddr,
    input  logic [plti_pkg::PDATA_W-1:0]        pwdata,
    output logic [plti_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    localparam int W     = plti_pkg::DATA_W;
    localparam int IDX_W = plti_pkg::IDX_W;
    localparam int CNT_W = plti_pkg::CNT_W;
    localparam int PTS_W = plti_pkg::PTS_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_PROBE,
        ST_CMP,
        ST_RDHI,
        ST_RDLO,
        ST_MUL,
        ST_DIV
    } t_state;

    t_state              r_state;
    logic [PTS_W-1:0]    r_points;
    logic                r_valid;
    logic signed [W-1:0] r_value;
    plti_pkg::t_outcome  r_outcome;
    logic signed [W-1:0] r_angle;
    logic [CNT_W-1:0]    r_n;
    logic [CNT_W-1:0]    r_first;
    logic [CNT_W-1:0]    r_count;
    logic [IDX_W-1:0]    r_hi_idx;
    logic signed [W-1:0] r_ahi;
    logic signed [W-1:0] r_vhi;
    logic signed [W-1:0] r_vlo;
    logic [W-1:0]        r_span;
    logic                r_neg;

    // Breakpoint memory, one write and one registered read port
    plti_pkg::t_entry    r_mem [plti_pkg::MAX_POINTS];
    plti_pkg::t_entry    r_rdata;

    logic                accept;
    logic                wr_en;
    logic                cfg_wr;
    logic [IDX_W-1:0]    rd_addr;
    logic [CNT_W-1:0]    pts_sat;
    logic [CNT_W-1:0]    n_m1;
    logic [CNT_W-1:0]    half;
    logic [CNT_W-1:0]    probe;
    logic [CNT_W-1:0]    hi_clamp;
    logic signed [W:0]   da;
    logic signed [W:0]   dv;
    logic signed [W:0]   span;
    logic [W-1:0]        mag_da;
    logic [W-1:0]        mag_dv;
    logic                mul_start;
    logic                mul_done;
    logic [2*W-1:0]      mul_prod;
    logic                ovf;
    logic                div_start;
    logic                div_done;
    logic [W-1:0]        div_quo;
    logic [W+1:0]        q_ext;
    logic [W+1:0]        q_signed;
    logic [W+1:0]        sum;
    logic signed [W-1:0] sum_sat;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign wr_en  = accept && (i_operation == plti_pkg::OP_WRITE)
                    && (int'(i_entry_index) < plti_pkg::MAX_POINTS);

    // APB register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == plti_pkg::REG_POINTS)
                    ? plti_pkg::PDATA_W'(r_points) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= '0;
        end else if (cfg_wr && paddr[2] == plti_pkg::REG_POINTS) begin
            r_points <= pwdata[PTS_W-1:0];
        end
    end

    // Search arithmetic
    always_comb begin
        pts_sat  = (int'(r_points) > plti_pkg::MAX_POINTS)
                   ? CNT_W'(plti_pkg::MAX_POINTS) : CNT_W'(r_points);
        n_m1     = r_n - CNT_W'(1);
        half     = r_count >> 1;
        probe    = r_first + half;
        if (r_first == '0) begin
            hi_clamp = CNT_W'(1);
        end else if (r_first > n_m1) begin
            hi_clamp = n_m1;
        end else begin
            hi_clamp = r_first;
        end
    end

    // Read address issued by each state; data arrives in the next state
    always_comb begin
        case (r_state)
            ST_FIRST: rd_addr = n_m1[IDX_W-1:0];
            ST_PROBE: rd_addr = (r_count == '0) ? hi_clamp[IDX_W-1:0]
                                                : probe[IDX_W-1:0];
            ST_RDHI:  rd_addr = r_hi_idx - IDX_W'(1);
            default:  rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_entry_index] <= '{angle: i_entry_angle, value: i_entry_value};
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Differences for the interpolation (low entry on the read port)
    always_comb begin
        da     = {r_angle[W-1], r_angle} - {r_rdata.angle[W-1], r_rdata.angle};
        dv     = {r_vhi[W-1], r_vhi} - {r_rdata.value[W-1], r_rdata.value};
        span   = {r_ahi[W-1], r_ahi} - {r_rdata.angle[W-1], r_rdata.angle};
        mag_da = da[W] ? W'(-da) : da[W-1:0];
        mag_dv = dv[W] ? W'(-dv) : dv[W-1:0];
    end

    assign mul_start = (r_state == ST_RDLO) && !span[W] && (span != '0);
    // Quotient of 2^W or more always saturates the result
    assign ovf       = (mul_prod[2*W-1:W] >= r_span);
    assign div_start = (r_state == ST_MUL) && mul_done && !ovf;

    plti_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (mag_da),
        .i_mplier (mag_dv),
        .o_done   (mul_done),
        .o_prod   (mul_prod)
    );

    plti_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mul_prod),
        .i_divisor  (r_span),
        .o_done     (div_done),
        .o_quo      (div_quo)
    );

    // Apply sign, add low value, saturate to Q4.11
    always_comb begin
        q_ext    = {2'b00, div_quo};
        q_signed = r_neg ? -q_ext : q_ext;
        sum      = {{2{r_vlo[W-1]}}, r_vlo} + q_signed;
        if (!sum[W+1] && sum[W:W-1] != 2'b00) begin
            sum_sat = plti_pkg::VAL_MAX;
        end else if (sum[W+1] && sum[W:W-1] != 2'b11) begin
            sum_sat = plti_pkg::VAL_MIN;
        end else begin
            sum_sat = sum[W-1:0];
        end
    end

    // Sequencer with registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= 1'b0;
            r_outcome <= plti_pkg::OUT_WRITE;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_angle <= i_angle;
                        r_n     <= pts_sat;
                        if (i_operation == plti_pkg::OP_WRITE) begin
                            r_valid   <= 1'b1;
                            r_value   <= '0;
                            r_outcome <= plti_pkg::OUT_WRITE;
                        end else if (pts_sat == '0) begin
                            r_valid   <= 1'b1;
                            r_value   <= '0;
                            r_outcome <= plti_pkg::OUT_EMPTY;
                        end else begin
                            r_state <= ST_FIRST;
                        end
                    end
                end
                ST_FIRST: begin
                    if (r_n == CNT_W'(1)) begin
                        r_valid   <= 1'b1;
                        r_value   <= r_rdata.value;
                        r_outcome <= plti_pkg::OUT_SINGLE;
                        r_state   <= ST_IDLE;
                    end else if (r_angle <= r_rdata.angle) begin
                        r_valid   <= 1'b1;
                        r_value   <= r_rdata.value;
                        r_outcome <= plti_pkg::OUT_BELOW;
                        r_state   <= ST_IDLE;
                    end else begin
                        r_state <= ST_LAST;
                    end
                end
                ST_LAST: begin
                    if (r_angle >= r_rdata.angle) begin
                        r_valid   <= 1'b1;
                        r_value   <= r_rdata.value;
                        r_outcome <= plti_pkg::OUT_ABOVE;
                        r_state   <= ST_IDLE;
                    end else begin
                        r_first <= '0;
                        r_count <= r_n;
                        r_state <= ST_PROBE;
                    end
                end
                ST_PROBE: begin
                    if (r_count == '0) begin
                        r_hi_idx <= hi_clamp[IDX_W-1:0];
                        r_state  <= ST_RDHI;
                    end else begin
                        r_state <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    // upper-bound step: move past probes not above the angle
                    if (!(r_angle < r_rdata.angle)) begin
                        r_first <= probe + CNT_W'(1);
                        r_count <= r_count - half - CNT_W'(1);
                    end else begin
                        r_count <= half;
                    end
                    r_state <= ST_PROBE;
                end
                ST_RDHI: begin
                    r_ahi   <= r_rdata.angle;
                    r_vhi   <= r_rdata.value;
                    r_state <= ST_RDLO;
                end
                ST_RDLO: begin
                    if (span[W] || span == '0) begin
                        r_valid   <= 1'b1;
                        r_value   <= r_rdata.value;
                        r_outcome <= plti_pkg::OUT_FLAT;
                        r_state   <= ST_IDLE;
                    end else begin
                        r_vlo   <= r_rdata.value;
                        r_span  <= span[W-1:0];
                        r_neg   <= da[W] ^ dv[W];
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (mul_done) begin
                        if (ovf) begin
                            r_valid   <= 1'b1;
                            r_value   <= r_neg ? plti_pkg::VAL_MIN : plti_pkg::VAL_MAX;
                            r_outcome <= plti_pkg::OUT_INTERP;
                            r_state   <= ST_IDLE;
                        end else begin
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_valid   <= 1'b1;
                        r_value   <= sum_sat;
                        r_outcome <= plti_pkg::OUT_INTERP;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid   = r_valid;
    assign o_value   = r_value;
    assign o_outcome = r_outcome;

    // A result only follows an accepted write or a running sample
    `PLTI_ASSERT_IMPL(a_valid_cause, i_clk, i_rst_n, o_valid, $past(busy) || $past(start))
    // A write is answered in the next cycle with the write outcome
    `PLTI_ASSERT_NEXT(a_write_done, i_clk, i_rst_n, start && !busy && !i_operation, o_valid && o_outcome == plti_pkg::OUT_WRITE)
    // A sample never ends without delivering its result
    `PLTI_ASSERT_IMPL(a_busy_result, i_clk, i_rst_n, $fell(busy) && $past(i_rst_n), o_valid)

endmodule
